### hdl/a85d_pkg.sv
// Shared types, character codes and helpers for the ASCII85 stream decoder.
package a85d_pkg;

  // Character codes
  localparam logic [7:0] CHAR_BIAS  = 8'd33;   // '!' is digit zero
  localparam logic [7:0] CHAR_MAX   = 8'd126;  // '~', highest printable byte
  localparam logic [7:0] CHAR_Z     = 8'h7A;   // 'z'
  localparam logic [7:0] CHAR_TILDE = 8'h7E;   // '~'
  localparam logic [7:0] CHAR_GT    = 8'h3E;   // '>'

  // Powers of 85 for 'u' padding of a short final group
  localparam logic [19:0] POW85_1 = 20'd85;
  localparam logic [19:0] POW85_2 = 20'd7225;
  localparam logic [19:0] POW85_3 = 20'd614125;

  localparam logic [2:0] GROUP_DIGITS = 3'd5;
  localparam logic [2:0] GROUP_BYTES  = 3'd4;

  // Result error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_END  = 2'd1;
  localparam logic [1:0] ERR_BAD_CHR = 2'd2;

  // Job queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // One unit of work for the back end: nbytes == 0 means a single beat with
  // no data byte, carrying only the end flag and error code.
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  nbytes;
    logic        stream_end;
    logic [1:0]  err;
  } job_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'd0) || (c == 8'd9) || (c == 8'd10) || (c == 8'd12) ||
               (c == 8'd13) || (c == 8'd32);
  endfunction

endpackage

### hdl/a85d_front.sv
// Front end: holds the raw byte one beat, accumulates base-85 groups, builds jobs.
module a85d_front
  import a85d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       job_push,
  output job_t       job
);

  logic [31:0] group_r, group_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_valid_r, held_valid_nxt;

  logic        accept;
  logic        held_space, held_bad, held_zgrp, end_ok;
  logic [6:0]  digit;
  logic [19:0] pow;
  logic [31:0] mul_a;
  logic [19:0] mul_b;
  logic [51:0] prod;
  logic [31:0] acc;
  logic [2:0]  count_inc;
  logic        job_valid;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign held_space = is_space(held_r);
  assign held_bad   = (held_r < CHAR_BIAS) || (held_r > CHAR_MAX);
  assign held_zgrp  = (held_r == CHAR_Z) && (count_r == 3'd0);
  assign digit      = 7'(held_r - CHAR_BIAS);
  assign end_ok     = held_valid_r && (held_r == CHAR_TILDE) && (in_tdata == CHAR_GT);
  assign count_inc  = count_r + 3'd1;

  // Padding k = 5-m digits of 84 gives (v+1)*85^k - 1
  always_comb begin
    case (count_r)
      3'd2:    pow = POW85_3;
      3'd3:    pow = POW85_2;
      3'd4:    pow = POW85_1;
      default: pow = 20'd0;
    endcase
  end

  // One shared multiplier: digit step or final padding
  assign mul_a = in_tlast ? (group_r + 32'd1) : group_r;
  assign mul_b = in_tlast ? pow : POW85_1;
  assign prod  = mul_a * mul_b;
  assign acc   = in_tlast ? (prod[31:0] - 32'd1) : (prod[31:0] + {25'd0, digit});

  always_comb begin
    group_nxt      = group_r;
    count_nxt      = count_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    job_valid      = 1'b0;
    job            = '{value: 32'd0, nbytes: 3'd0, stream_end: 1'b0, err: ERR_NONE};
    if (accept) begin
      if (!in_tlast) begin
        held_nxt       = in_tdata;
        held_valid_nxt = 1'b1;
        if (held_valid_r && !held_space) begin
          if (held_bad) begin
            job_valid = 1'b1;
            job.err   = ERR_BAD_CHR;
          end else if (held_zgrp) begin
            job_valid  = 1'b1;
            job.nbytes = GROUP_BYTES;
          end else if (count_inc == GROUP_DIGITS) begin
            job_valid  = 1'b1;
            job.value  = acc;
            job.nbytes = GROUP_BYTES;
            group_nxt  = 32'd0;
            count_nxt  = 3'd0;
          end else begin
            group_nxt = acc;
            count_nxt = count_inc;
          end
        end
      end else begin
        job_valid       = 1'b1;
        job.stream_end  = 1'b1;
        if (end_ok && count_r >= 3'd2) begin
          job.value  = acc;
          job.nbytes = count_r - 3'd1;
        end else if (!end_ok) begin
          job.err = ERR_NO_END;
        end
        group_nxt      = 32'd0;
        count_nxt      = 3'd0;
        held_nxt       = 8'd0;
        held_valid_nxt = 1'b0;
      end
    end
  end

  assign job_push = job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r      <= 32'd0;
      count_r      <= 3'd0;
      held_r       <= 8'd0;
      held_valid_r <= 1'b0;
    end else begin
      group_r      <= group_nxt;
      count_r      <= count_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

### hdl/a85d_queue.sv
// Short job queue between front and back ends.
module a85d_queue
  import a85d_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/a85d_back.sv
// Back end: splits each job into result beats into a registered output stage.
module a85d_back
  import a85d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [2:0] out_tuser,
  output logic       out_tlast
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, bvalid_nxt;
  logic       last_r, last_nxt;
  logic [1:0] err_r, err_nxt;

  logic       load;
  logic       has_bytes;
  logic       final_beat;
  logic [1:0] last_idx;
  logic [7:0] sel_byte;

  assign load       = !valid_r || out_tready;
  assign has_bytes  = (head.nbytes != 3'd0);
  assign last_idx   = 2'(head.nbytes - 3'd1);
  assign final_beat = !has_bytes || (idx_r == last_idx);

  // Big-endian: first beat carries the top byte
  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.value[31:24];
      2'd1:    sel_byte = head.value[23:16];
      2'd2:    sel_byte = head.value[15:8];
      default: sel_byte = head.value[7:0];
    endcase
  end

  always_comb begin
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    bvalid_nxt = bvalid_r;
    last_nxt   = last_r;
    err_nxt    = err_r;
    q_pop      = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        byte_nxt   = has_bytes ? sel_byte : 8'd0;
        bvalid_nxt = has_bytes;
        last_nxt   = head.stream_end && final_beat;
        err_nxt    = head.err;
        if (final_beat) begin
          idx_nxt = 2'd0;
          q_pop   = 1'b1;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    last_r   <= last_nxt;
    err_r    <= err_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = {err_r, bvalid_r};
  assign out_tlast  = last_r;

endmodule

### hdl/ascii85_stream_decoder_core.sv
// Top level of the streaming ASCII85 decoder: front end, job queue, back end.
//
// Usage
//   Input channel (in_*): one raw stream byte per beat in in_tdata, with
//   in_tlast high on the final byte of a stream. Whitespace is skipped,
//   'z' gives four zero bytes, five digits give four bytes big-endian.
//   Output channel (out_*): one result per beat. out_tdata is the decoded
//   byte, out_tuser[0] says it is a real byte, out_tuser[2:1] is the error
//   (none, end mark missing, bad character dropped), out_tlast ends a stream.
//   Every stream ends with exactly one beat carrying out_tlast.
// Input to output
//   The raw byte is held back one beat so the '~>' end mark can be seen on
//   the final beat; results of a byte appear when the next byte is taken.
//   The job is written to the queue at that accepting edge and is loaded into
//   the registered output stage once that stage is free and the job is at the head.
// Throughput
//   One input beat per cycle while the job queue has room. The output runs
//   at one beat per cycle while out_tready is high; a group or 'z' costs
//   up to four output beats, so dense 'z' runs are paced by the output side.
// Reset and stalls
//   rst_n (synchronous, active low) empties the queue and output stage and
//   clears the group and held byte. A stalled receiver holds the output
//   beat; the queue then fills and in_tready drops.
module ascii85_stream_decoder_core
  import a85d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // in_last
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] byte_valid, [2:1] error_code
  output logic       out_tlast   // stream_end
);

  job_t job;
  job_t head;
  logic job_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // classifies bytes, runs the base-85 accumulator
  a85d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job)
  );

  // decouples input acceptance from output serialisation
  a85d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // one job becomes one to four result beats
  a85d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // data beats never carry an error
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ERR_NONE)
    else $error("data beat with error code");

  // a missing end mark always closes the stream
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == ERR_NO_END |-> out_tlast && !out_tuser[0])
    else $error("missing end mark without stream end");

  // a dropped character never ends a stream and carries no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == ERR_BAD_CHR |-> !out_tlast && out_tdata == 8'd0)
    else $error("bad character beat malformed");

  // no push is lost to a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full)
    else $error("job pushed into full queue");

endmodule
